FILE: design/isfi_pkg.sv
// ----------------------------------------------------------------------------
// isfi_pkg: shared types, constants and the divider step function
// Work item, divider stage record and playback mode codes for the frame
// index selector.
// ----------------------------------------------------------------------------
package isfi_pkg;

   localparam int MAX_FRAMES = 1024;
   localparam int INDEX_W    = 10;
   localparam int COUNT_W    = 11;
   localparam int PERIOD_W   = 11;
   localparam int ELAPSED_W  = 32;
   localparam int DELAY_W    = 31;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W     = 2;
   localparam int QCNT_W     = 3;

   typedef enum logic [2:0] {
      MODE_HOLD          = 3'd0,
      MODE_ONCE          = 3'd1,
      MODE_ONCE_REVERSE  = 3'd2,
      MODE_LOOP          = 3'd3,
      MODE_LOOP_REVERSE  = 3'd4,
      MODE_PING          = 3'd5,
      MODE_PING_REVERSE  = 3'd6
   } mode_type;

   localparam logic [2:0] MODE_UNUSED = 3'd7;

   typedef struct packed {
      mode_type              mode;
      logic [INDEX_W-1:0]    idx;
      logic [INDEX_W-1:0]    last;
      logic [COUNT_W-1:0]    count;
      logic [PERIOD_W-1:0]   period;
      logic [DELAY_W-1:0]    delay;
      logic [ELAPSED_W-1:0]  elapsed;
   } job_type;

   typedef struct packed {
      mode_type              mode;
      logic [INDEX_W-1:0]    idx;
      logic [INDEX_W-1:0]    last;
      logic [COUNT_W-1:0]    count;
      logic [PERIOD_W-1:0]   period;
      logic [DELAY_W-1:0]    delay;
      logic [ELAPSED_W-1:0]  dvd;
      logic [DELAY_W:0]      rem;
      logic [ELAPSED_W-1:0]  quo;
      logic [COUNT_W-1:0]    rc;
      logic [PERIOD_W-1:0]   rp;
   } stage_type;

   function automatic stage_type div_step(stage_type s);
      stage_type             o;
      logic [DELAY_W:0]      r;
      logic                  ge;
      logic [COUNT_W-1:0]    tc;
      logic [PERIOD_W:0]     tp;
      o  = s;
      r  = {s.rem[DELAY_W-1:0], s.dvd[ELAPSED_W-1]};
      ge = (r >= {1'b0, s.delay});
      o.rem = ge ? (r - {1'b0, s.delay}) : r;
      o.dvd = {s.dvd[ELAPSED_W-2:0], 1'b0};
      o.quo = {s.quo[ELAPSED_W-2:0], ge};
      tc = {s.rc[COUNT_W-2:0], ge};
      o.rc = (tc >= s.count) ? (tc - s.count) : tc;
      tp = {s.rp, ge};
      if (tp >= {1'b0, s.period}) begin
         tp = tp - {1'b0, s.period};
      end
      o.rp = tp[PERIOD_W-1:0];
      return o;
   endfunction

endpackage

FILE: design/isfi_front.sv
// ----------------------------------------------------------------------------
// isfi_front: request classifier
// Saturates count and start frame, forms the elapsed time and folds every
// trivial case into a hold word.
// ----------------------------------------------------------------------------
module isfi_front (
   input  logic [2:0]                     req_mode,
   input  logic [9:0]                     req_start_index,
   input  logic signed [31:0]             req_frame_delay,
   input  logic signed [31:0]             req_key_time,
   input  logic signed [31:0]             req_now_time,
   input  logic [10:0]                    req_frame_count,
   output isfi_pkg::job_type              job
);

   logic [isfi_pkg::COUNT_W-1:0]  cnt;
   logic [isfi_pkg::INDEX_W-1:0]  last;
   logic [isfi_pkg::INDEX_W-1:0]  idx;
   logic [32:0]                   diff;
   logic                          hold;
   logic                          is_ping;

   always_comb begin
      cnt  = (req_frame_count > 11'(isfi_pkg::MAX_FRAMES)) ?
             11'(isfi_pkg::MAX_FRAMES) : req_frame_count;
      last = 10'(cnt - 11'd1);
      idx  = (req_start_index > last) ? last : req_start_index;
      diff = {req_now_time[31], req_now_time} - {req_key_time[31], req_key_time};
      is_ping = (req_mode == isfi_pkg::MODE_PING) ||
                (req_mode == isfi_pkg::MODE_PING_REVERSE);
      hold = (req_mode == isfi_pkg::MODE_HOLD) || (req_mode == isfi_pkg::MODE_UNUSED) ||
             req_frame_delay[31] || (req_frame_delay == 32'sd0);

      job.mode    = isfi_pkg::mode_type'(req_mode);
      job.idx     = idx;
      job.last    = last;
      job.count   = cnt;
      job.period  = 11'({cnt, 1'b0} - 12'd2);
      job.delay   = req_frame_delay[30:0];
      job.elapsed = diff[32] ? 32'd0 : diff[31:0];

      if (cnt == 11'd0) begin
         job.mode = isfi_pkg::MODE_HOLD;
         job.idx  = '0;
      end else if (hold) begin
         job.mode = isfi_pkg::MODE_HOLD;
      end else if (is_ping && (cnt <= 11'd1)) begin
         job.mode = isfi_pkg::MODE_HOLD;
         job.idx  = '0;
      end
   end

endmodule

FILE: design/isfi_queue.sv
// ----------------------------------------------------------------------------
// isfi_queue: work queue
// Short FIFO of classified words between front and back.
// ----------------------------------------------------------------------------
module isfi_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  isfi_pkg::job_type    push_data,
   input  logic                 pop,
   output logic                 full,
   output logic                 empty,
   output isfi_pkg::job_type    head
);

   isfi_pkg::job_type                mem_ff [isfi_pkg::QUEUE_DEPTH];
   logic [isfi_pkg::QPTR_W-1:0]      wr_ff, wr_in;
   logic [isfi_pkg::QPTR_W-1:0]      rd_ff, rd_in;
   logic [isfi_pkg::QCNT_W-1:0]      cnt_ff, cnt_in;

   assign full  = (cnt_ff == 3'(isfi_pkg::QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + {2'b0, push} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

FILE: design/isfi_back.sv
// ----------------------------------------------------------------------------
// isfi_back: step divider and frame walk
// One quotient bit per stage, with running step remainders modulo count and
// pingpong period, then the mode walk into the output register.
// ----------------------------------------------------------------------------
module isfi_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  isfi_pkg::job_type    q_head,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [9:0]           rsp_frame_index
);

   localparam int NSTEPS = isfi_pkg::ELAPSED_W;

   isfi_pkg::stage_type   st_ff [NSTEPS+1];
   logic [NSTEPS:0]       vld_ff;
   logic                  out_vld_ff;
   logic [9:0]            out_ff, out_in;
   logic                  adv;
   isfi_pkg::stage_type   fin;
   logic [9:0]            span;
   logic [10:0]           ls;
   logic [9:0]            lp;
   logic [11:0]           ps;
   logic [10:0]           ph;

   assign adv       = !out_vld_ff || !rsp_stall;
   assign q_pop     = adv && !q_empty;
   assign rsp_valid = out_vld_ff;
   assign rsp_frame_index = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= !q_empty;
      end
      if (adv) begin
         st_ff[0].mode   <= q_head.mode;
         st_ff[0].idx    <= q_head.idx;
         st_ff[0].last   <= q_head.last;
         st_ff[0].count  <= q_head.count;
         st_ff[0].period <= q_head.period;
         st_ff[0].delay  <= q_head.delay;
         st_ff[0].dvd    <= q_head.elapsed;
         st_ff[0].rem    <= '0;
         st_ff[0].quo    <= '0;
         st_ff[0].rc     <= '0;
         st_ff[0].rp     <= '0;
      end
   end

   for (genvar k = 1; k <= NSTEPS; k++) begin : g_step
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         if (adv) begin
            st_ff[k] <= isfi_pkg::div_step(st_ff[k-1]);
         end
      end
   end

   always_comb begin
      fin  = st_ff[NSTEPS];
      span = fin.last - fin.idx;
      ls   = {1'b0, fin.rc[9:0]} + {1'b0, fin.idx};
      if (ls >= fin.count) begin
         ls = ls - fin.count;
      end
      lp = ls[9:0];
      ps = {1'b0, fin.rp} + {2'b0, fin.idx} +
           ((fin.mode == isfi_pkg::MODE_PING_REVERSE) ? {2'b0, fin.last} : 12'd0);
      if (ps >= {1'b0, fin.period}) begin
         ps = ps - {1'b0, fin.period};
      end
      ph = ps[10:0];
      case (fin.mode)
         isfi_pkg::MODE_ONCE: begin
            out_in = (fin.quo >= {22'd0, span}) ? fin.last : fin.idx + fin.quo[9:0];
         end
         isfi_pkg::MODE_ONCE_REVERSE: begin
            out_in = (fin.quo >= {22'd0, span}) ? 10'd0 : span - fin.quo[9:0];
         end
         isfi_pkg::MODE_LOOP:         out_in = lp;
         isfi_pkg::MODE_LOOP_REVERSE: out_in = fin.last - lp;
         isfi_pkg::MODE_PING, isfi_pkg::MODE_PING_REVERSE: begin
            out_in = (ph < fin.count) ? ph[9:0] : 10'(fin.period - ph);
         end
         default:                     out_in = fin.idx;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= vld_ff[NSTEPS];
      end
      if (adv) begin
         out_ff <= out_in;
      end
   end

endmodule

FILE: design/image_sequence_frame_index_top.sv
// ----------------------------------------------------------------------------
// image_sequence_frame_index_top: image sequence frame selector
// Picks the image to show from count, start frame, mode, delay and times.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | mode, start_index, delay, times, count
//   rsp     | out       | rsp_valid/stall    | frame_index
//
// One word per cycle sustained while rsp_stall is low; the 32-stage
// one-bit-per-stage step divider sits between entry and output registers.
// A 4-word queue sits between classifier and divider pipeline.
// The whole back pipeline holds while rsp_stall holds a waiting word.
// Synchronous reset clears valid bits, queue pointers and queue count only.
// ----------------------------------------------------------------------------
module image_sequence_frame_index_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [2:0]           req_mode,
   input  logic [9:0]           req_start_index,
   input  logic signed [31:0]   req_frame_delay,
   input  logic signed [31:0]   req_key_time,
   input  logic signed [31:0]   req_now_time,
   input  logic [10:0]          req_frame_count,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [9:0]           rsp_frame_index
);

   isfi_pkg::job_type   job;
   isfi_pkg::job_type   head;
   logic                full;
   logic                empty;
   logic                pop;

   assign req_stall = full;

   isfi_front u_front (
      .req_mode        (req_mode),
      .req_start_index (req_start_index),
      .req_frame_delay (req_frame_delay),
      .req_key_time    (req_key_time),
      .req_now_time    (req_now_time),
      .req_frame_count (req_frame_count),
      .job             (job)
   );

   isfi_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && !full),
      .push_data (job),
      .pop       (pop),
      .full      (full),
      .empty     (empty),
      .head      (head)
   );

   isfi_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (empty),
      .q_head          (head),
      .q_pop           (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_frame_index (rsp_frame_index)
   );

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: frame index selector testbench
// Drives directed and random frame queries with random request gaps and
// response stalls, predicts each frame index and checks results in order.
// ----------------------------------------------------------------------------
module tb_top;

   typedef struct {
      logic [2:0]         mode;
      logic [9:0]         start;
      logic signed [31:0] delay;
      logic signed [31:0] key_t;
      logic signed [31:0] now_t;
      logic [10:0]        count;
      int                 known;
   } query_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [2:0]          req_mode = '0;
   logic [9:0]          req_start_index = '0;
   logic signed [31:0]  req_frame_delay = '0;
   logic signed [31:0]  req_key_time = '0;
   logic signed [31:0]  req_now_time = '0;
   logic [10:0]         req_frame_count = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [9:0]          rsp_frame_index;

   logic [9:0] frame_expected[$];
   int errors = 0;
   int n_sent = 0;
   int n_got = 0;
   int idle_cycles = 0;
   bit sending_done = 0;

   image_sequence_frame_index_top u_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [9:0] select_frame(query_type q);
      logic [63:0]        cnt, last, idx, steps, lp, period, phase, res;
      logic signed [32:0] elapsed;
      cnt = 64'(q.count);
      if (cnt > 64'(isfi_pkg::MAX_FRAMES)) cnt = 64'(isfi_pkg::MAX_FRAMES);
      if (cnt == 64'd0) return 10'd0;
      last = cnt - 64'd1;
      idx = (64'(q.start) > last) ? last : 64'(q.start);
      if (q.mode == isfi_pkg::MODE_HOLD || q.mode > isfi_pkg::MODE_PING_REVERSE ||
          q.delay <= 0) return 10'(idx);
      elapsed = 33'(q.now_t) - 33'(q.key_t);
      steps = (elapsed <= 0) ? 64'd0 : 64'(elapsed) / 64'(q.delay);
      case (q.mode)
         isfi_pkg::MODE_ONCE: res = (steps >= last - idx) ? last : idx + steps;
         isfi_pkg::MODE_ONCE_REVERSE: res = (steps >= last - idx) ? 64'd0 : last - idx - steps;
         isfi_pkg::MODE_LOOP, isfi_pkg::MODE_LOOP_REVERSE: begin
            lp = (steps % cnt + idx) % cnt;
            res = (q.mode == isfi_pkg::MODE_LOOP) ? lp : last - lp;
         end
         default: begin
            if (cnt <= 64'd1) return 10'd0;
            period = 2 * cnt - 2;
            phase = (steps % period + idx +
                     ((q.mode == isfi_pkg::MODE_PING_REVERSE) ? last : 64'd0)) % period;
            res = (phase < cnt) ? phase : period - phase;
         end
      endcase
      return 10'(res);
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic signed [31:0] rand_time();
      case ($urandom_range(0, 3))
         0: return 32'($urandom);
         1: return 32'($urandom_range(0, 32'h0008_0000));
         2: return 32'sh7FFF_FFFF - 32'($urandom_range(0, 1000));
         default: return 32'sh8000_0000 + 32'($urandom_range(0, 1000));
      endcase
   endfunction

   function automatic query_type rand_query();
      query_type q;
      q.mode  = 3'($urandom_range(0, 7));
      q.count = ($urandom_range(0, 9) < 7) ? 11'($urandom_range(0, 20))
              : 11'($urandom_range(0, 2047));
      q.start = ($urandom_range(0, 1) != 0) ? 10'($urandom_range(0, 24)) : 10'($urandom);
      case ($urandom_range(0, 5))
         0: q.delay = 32'($urandom);
         1: q.delay = 32'(-$urandom_range(0, 5));
         2: q.delay = 32'($urandom_range(1, 8));
         default: q.delay = 32'($urandom_range(1, 32'h0004_0000));
      endcase
      q.key_t = rand_time();
      q.now_t = ($urandom_range(0, 3) == 0) ? rand_time()
              : q.key_t + 32'($urandom_range(0, 32'h0100_0000));
      q.known = -1;
      return q;
   endfunction

   task automatic send_word(query_type q);
      logic [9:0] exp_frame;
      exp_frame = (q.known >= 0) ? 10'(q.known) : select_frame(q);
      req_valid       <= 1'b1;
      req_mode        <= q.mode;
      req_start_index <= q.start;
      req_frame_delay <= q.delay;
      req_key_time    <= q.key_t;
      req_now_time    <= q.now_t;
      req_frame_count <= q.count;
      frame_expected = {frame_expected, exp_frame};
      do @(posedge clock); while (req_stall);
      n_sent++;
   endtask

   task automatic send_gap();
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   query_type directed [22];

   initial begin
      query_type q;
      directed = '{
         '{isfi_pkg::MODE_LOOP, 10'd5, 32'sh0001_0000, 0, 32'sh0003_0000, 11'd0, 0},
         '{isfi_pkg::MODE_HOLD, 10'd1023, 32'sh0001_0000, 0, 0, 11'd1024, 1023},
         '{isfi_pkg::MODE_HOLD, 10'd9, 32'sh0001_0000, 0, 0, 11'd4, 3},
         '{isfi_pkg::MODE_HOLD, 10'd1023, 1, 0, 0, 11'd2047, 1023},
         '{isfi_pkg::MODE_UNUSED, 10'd2, 32'sh0001_0000, 0, 32'sh0009_0000, 11'd8, 2},
         '{isfi_pkg::MODE_ONCE, 10'd2, 32'sh0000_0000, 0, 32'sh0009_0000, 11'd8, 2},
         '{isfi_pkg::MODE_LOOP, 10'd2, 32'sh8000_0000, 0, 32'sh0009_0000, 11'd8, 2},
         '{isfi_pkg::MODE_ONCE, 10'd2, 32'sh0001_0000, 32'sh0009_0000, 0, 11'd8, 2},
         '{isfi_pkg::MODE_PING, 10'd0, 32'sh0001_0000, 0, 32'sh0005_0000, 11'd1, 0},
         '{isfi_pkg::MODE_PING_REVERSE, 10'd0, 32'sh0001_0000, 0, 32'sh0005_0000,
           11'd1, 0},
         '{isfi_pkg::MODE_ONCE, 10'd1, 32'sh0001_0000, 0, 32'sh0003_0000, 11'd8, -1},
         '{isfi_pkg::MODE_ONCE, 10'd1, 32'sh0001_0000, 0, 32'sh0030_0000, 11'd8, 7},
         '{isfi_pkg::MODE_ONCE_REVERSE, 10'd1, 32'sh0001_0000, 0, 32'sh0003_0000,
           11'd8, -1},
         '{isfi_pkg::MODE_ONCE_REVERSE, 10'd1, 32'sh0001_0000, 0, 32'sh0030_0000,
           11'd8, 0},
         '{isfi_pkg::MODE_LOOP, 10'd3, 32'sh0001_0000, 0, 32'sh0009_0000, 11'd8, -1},
         '{isfi_pkg::MODE_LOOP_REVERSE, 10'd3, 32'sh0001_0000, 0, 32'sh0009_0000,
           11'd8, -1},
         '{isfi_pkg::MODE_PING, 10'd3, 32'sh0001_0000, 0, 32'sh0009_0000, 11'd8, -1},
         '{isfi_pkg::MODE_PING_REVERSE, 10'd3, 32'sh0001_0000, 0, 32'sh0009_0000,
           11'd8, -1},
         '{isfi_pkg::MODE_LOOP, 10'd1023, 1, 32'sh8000_0000, 32'sh7FFF_FFFF,
           11'd1024, -1},
         '{isfi_pkg::MODE_PING, 10'd1023, 1, 32'sh8000_0000, 32'sh7FFF_FFFF,
           11'd2047, -1},
         '{isfi_pkg::MODE_PING_REVERSE, 10'd0, 32'sh7FFF_FFFF, 32'sh8000_0000,
           32'sh7FFF_FFFF, 11'd2, -1},
         '{isfi_pkg::MODE_LOOP_REVERSE, 10'd0, 32'sh0000_0003, 0, 32'sh0000_0002,
           11'd5, 4}
      };
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) begin
         send_word(directed[i]);
         if (i % 3 == 2) send_gap();
      end
      repeat (1500) begin
         q = rand_query();
         send_word(q);
         send_gap();
      end
      req_valid <= 1'b0;
      sending_done = 1;
   end

   initial begin
      int g;
      @(negedge reset);
      forever begin
         @(posedge clock);
         g = gap_len();
         if ($urandom_range(0, 99) < 25 && g > 0) begin
            rsp_stall <= 1'b1;
            repeat (g) @(posedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frame_expected.size() == 0) begin
            $error("frame_index: unexpected word, actual %0d", rsp_frame_index);
            errors++;
         end else begin
            if (rsp_frame_index !== frame_expected[0]) begin
               $error("frame_index: expected %0d actual %0d",
                      frame_expected[0], rsp_frame_index);
               errors++;
            end
            void'(frame_expected.pop_front());
         end
         n_got++;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (sending_done && frame_expected.size() == 0 || idle_cycles >= 5000);
      if (idle_cycles >= 5000) begin
         $display("[image_sequence_frame_index_top] ERROR");
         $finish;
      end
      repeat (60) @(posedge clock);
      $display("Ran %0d frame queries over all modes, got %0d words back",
               n_sent, n_got);
      if (errors == 0 && frame_expected.size() == 0)
         $display("[image_sequence_frame_index_top] OK");
      else
         $display("[image_sequence_frame_index_top] ERROR");
      $finish;
   end

endmodule
